### rtl/bdst_pkg.sv
package bdst_pkg;

    // Default table depth
    localparam int NUM_SLOTS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKED_MASK  = 1'b1;
    localparam logic [7:0]           LINKED_MASK_RST  = 8'h01;

    // Operations
    localparam logic [1:0] OP_INBOUND    = 2'd0;
    localparam logic [1:0] OP_SEND       = 2'd1;
    localparam logic [1:0] OP_APPROVE    = 2'd2;
    localparam logic [1:0] OP_DISCONNECT = 2'd3;

    // Inbound message kinds
    localparam logic [2:0] KIND_LONG_ID     = 3'd0;
    localparam logic [2:0] KIND_PASSTHROUGH = 3'd1;
    localparam logic [2:0] KIND_DISCONNECT  = 3'd2;
    localparam logic [2:0] KIND_LINK_ACK    = 3'd3;

    // Minor codes
    localparam logic [7:0] MINOR_UNAVAIL  = 8'hFF;
    localparam logic [7:0] MINOR_ACCEPTED = 8'h00;

    // Result codes
    localparam logic [2:0] RC_OK     = 3'd0;
    localparam logic [2:0] RC_RANGE  = 3'd1;
    localparam logic [2:0] RC_ABSENT = 3'd2;
    localparam logic [2:0] RC_ADDR   = 3'd3;
    localparam logic [2:0] RC_CHAN   = 3'd4;
    localparam logic [2:0] RC_FULL   = 3'd5;
    localparam logic [2:0] RC_KIND   = 3'd6;

    // Channel window for outbound messages
    localparam logic [5:0] CHAN_MIN = 6'd1;
    localparam logic [5:0] CHAN_MAX = 6'd32;

    // Link states
    localparam logic [1:0] LS_ABSENT = 2'd0;
    localparam logic [1:0] LS_NEW    = 2'd1;
    localparam logic [1:0] LS_ACK    = 2'd2;
    localparam logic [1:0] LS_READY  = 2'd3;

    // One slot of the table
    typedef struct packed {
        logic [1:0] link;
        logic [7:0] bus_addr;
        logic [5:0] channel;
        logic [7:0] status;
    } slot_entry_t;

    // Scan compare outcome
    typedef struct packed {
        logic hit;
        logic absent;
    } match_t;

    // Outbound check outcome
    typedef struct packed {
        logic [2:0] rc;
        logic [7:0] bus_addr;
        logic [5:0] channel;
    } send_chk_t;

    // One result beat
    typedef struct packed {
        logic [2:0] result_code;
        logic [3:0] slot_out;
        logic [7:0] bus_addr_out;
        logic [5:0] channel_out;
        logic       forward;
        logic [7:0] slot_status_out;
    } result_t;

endpackage

### rtl/bdst_if.sv
// Request channel
interface bdst_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] bus_addr;
    logic [5:0] channel;
    logic [2:0] msg_kind;
    logic [7:0] minor_code;
    logic [7:0] status_in;
    logic [4:0] dev_slot;
    logic       approve;

    modport source (
        output valid, op, bus_addr, channel, msg_kind, minor_code, status_in,
               dev_slot, approve,
        input  ready
    );
    modport sink (
        input  valid, op, bus_addr, channel, msg_kind, minor_code, status_in,
               dev_slot, approve,
        output ready
    );
endinterface

// Response channel
interface bdst_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_code;
    logic [3:0] slot_out;
    logic [7:0] bus_addr_out;
    logic [5:0] channel_out;
    logic       forward;
    logic [7:0] slot_status_out;

    modport source (
        output valid, result_code, slot_out, bus_addr_out, channel_out, forward,
               slot_status_out,
        input  ready
    );
    modport sink (
        input  valid, result_code, slot_out, bus_addr_out, channel_out, forward,
               slot_status_out,
        output ready
    );
endinterface

### rtl/bus_device_slot_table.sv
// Channel  Dir  Beat
// req      in   op, bus_addr, channel, msg_kind, minor_code, status_in, dev_slot, approve
// rsp      out  result_code, slot_out, bus_addr_out, channel_out, forward, slot_status_out
// wr_*     in   configuration write: wr_en, wr_index, wr_data
//
// One request at a time. An inbound message to a nonzero bus address scans slots
// 1..NUM_SLOTS-1 through the single table read port, one slot a cycle, and stops
// at the first match, else takes the first absent slot or reports the table full.
// Other requests run read, execute, result; an out-of-range slot goes straight to result.
// Reset empties the table at once through per-slot written flags; no clearing pass.
// req.ready is low while a request is at work; a stalled result holds the block
// before it returns to idle.
module bus_device_slot_table #(
    parameter int NUM_SLOTS = bdst_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bdst_req_if.sink                       req,
    bdst_rsp_if.source                     rsp,
    input  logic                           wr_en,
    input  logic [bdst_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [bdst_pkg::CFG_DATA_W-1:0] wr_data
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int SW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_EXEC = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic [1:0] op_reg;
    logic [7:0] baddr_reg;
    logic [5:0] chan_reg;
    logic [2:0] kind_reg;
    logic [7:0] minor_reg;
    logic [7:0] stin_reg;
    logic [4:0] ds_reg;
    logic       appr_reg;

    // Sequencer state
    logic [IW-1:0] cur_idx_reg, cur_idx_next;
    logic          alloc_reg, alloc_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic          free_vld_reg, free_vld_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    // Result and output registers
    bdst_pkg::result_t res_reg, res_next;
    logic              res_ld;
    bdst_pkg::result_t out_reg;
    logic              out_vld_reg;

    // Configuration registers
    logic [5:0] ctrl_chan_reg;
    logic [7:0] mask_reg;

    // Table port
    logic                  mem_wr_en;
    bdst_pkg::slot_entry_t mem_wr_data;
    logic [IW-1:0]         mem_rd_addr;
    bdst_pkg::slot_entry_t mem_rd_data;

    bdst_pkg::match_t      match;
    bdst_pkg::slot_entry_t ent;
    bdst_pkg::slot_entry_t ent_chk;
    bdst_pkg::slot_entry_t ent_new;
    bdst_pkg::send_chk_t   send;

    logic          accept;
    logic          out_free;
    logic          ds_in_range;
    logic [IW+4:0] ds_ext;
    logic [IW+3:0] slot_ext;
    logic [IW+4:0] req_ds_ext;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_vld_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign ds_in_range = (32'(req.dev_slot) < NUM_SLOTS);
    assign req_ds_ext  = {{IW{1'b0}}, req.dev_slot};
    assign ds_ext      = {{IW{1'b0}}, ds_reg};
    assign slot_ext    = {4'b0, cur_idx_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_chan_reg <= 6'd0;
            mask_reg      <= bdst_pkg::LINKED_MASK_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bdst_pkg::CFG_CTRL_CHANNEL: ctrl_chan_reg <= wr_data[5:0];
                bdst_pkg::CFG_LINKED_MASK:  mask_reg      <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.op;
            baddr_reg <= req.bus_addr;
            chan_reg  <= req.channel;
            kind_reg  <= req.msg_kind;
            minor_reg <= req.minor_code;
            stin_reg  <= req.status_in;
            ds_reg    <= req.dev_slot;
            appr_reg  <= req.approve;
        end
        if (res_ld)
        begin
            res_reg <= res_next;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    // Table and scan compare unit
    assign mem_rd_addr = (state_reg == S_SCAN) ? scan_reg[IW-1:0] : cur_idx_reg;

    bdst_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (cur_idx_reg),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bdst_match u_match (
        .entry    (mem_rd_data),
        .bus_addr (baddr_reg),
        .channel  (chan_reg),
        .result   (match)
    );

    // Entry under execution: a fresh allocation or the slot just read
    always_comb
    begin
        if (alloc_reg)
        begin
            ent.link     = bdst_pkg::LS_NEW;
            ent.bus_addr = baddr_reg;
            ent.channel  = chan_reg;
            ent.status   = 8'd0;
        end
        else
        begin
            ent = mem_rd_data;
        end
        ent_chk = ent;
        if (op_reg == bdst_pkg::OP_DISCONNECT)
        begin
            ent_chk.link = bdst_pkg::LS_ABSENT;
        end
    end

    bdst_send_chk u_send (
        .slot_zero    (cur_idx_reg == '0),
        .entry        (ent_chk),
        .ctrl_channel (ctrl_chan_reg),
        .result       (send)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cur_idx_next  = cur_idx_reg;
        alloc_next    = alloc_reg;
        scan_next     = scan_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        res_next      = '0;
        res_ld        = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_data   = ent;
        ent_new       = ent;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    alloc_next    = 1'b0;
                    free_vld_next = 1'b0;
                    scan_next     = SW'(1);
                    if (req.op == bdst_pkg::OP_INBOUND)
                    begin
                        if (req.bus_addr == 8'd0)
                        begin
                            cur_idx_next = '0;
                            state_next   = S_READ;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (ds_in_range)
                    begin
                        cur_idx_next = req_ds_ext[IW-1:0];
                        state_next   = S_READ;
                    end
                    else
                    begin
                        res_next.result_code = bdst_pkg::RC_RANGE;
                        res_next.slot_out    = req.dev_slot[3:0];
                        res_ld               = 1'b1;
                        state_next           = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read
                if (scan_reg < SW'(NUM_SLOTS))
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[IW-1:0];
                    scan_next    = scan_reg + SW'(1);
                end
                // Check the slot read in the cycle before
                if (chk_vld_reg)
                begin
                    if (match.hit)
                    begin
                        cur_idx_next = chk_idx_reg;
                        chk_vld_next = 1'b0;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        if (match.absent && !free_vld_reg)
                        begin
                            free_vld_next = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                        if (chk_idx_reg == IW'(NUM_SLOTS - 1))
                        begin
                            if (free_vld_reg)
                            begin
                                cur_idx_next = free_idx_reg;
                                alloc_next   = 1'b1;
                                state_next   = S_EXEC;
                            end
                            else if (match.absent)
                            begin
                                cur_idx_next = chk_idx_reg;
                                alloc_next   = 1'b1;
                                state_next   = S_EXEC;
                            end
                            else
                            begin
                                res_next.result_code = bdst_pkg::RC_FULL;
                                res_ld               = 1'b1;
                                state_next           = S_DONE;
                            end
                        end
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                res_ld     = 1'b1;
                state_next = S_DONE;
                if (op_reg == bdst_pkg::OP_INBOUND)
                begin
                    res_next.result_code = bdst_pkg::RC_OK;
                    res_next.forward     = 1'b1;
                    res_next.slot_out    = slot_ext[3:0];
                    case (kind_reg)
                        bdst_pkg::KIND_LONG_ID:
                        begin
                            if (minor_reg != bdst_pkg::MINOR_UNAVAIL)
                            begin
                                ent_new.status = stin_reg;
                            end
                        end
                        bdst_pkg::KIND_PASSTHROUGH: ;
                        bdst_pkg::KIND_DISCONNECT:
                        begin
                            ent_new.link = bdst_pkg::LS_ABSENT;
                        end
                        bdst_pkg::KIND_LINK_ACK:
                        begin
                            if (minor_reg == bdst_pkg::MINOR_ACCEPTED)
                            begin
                                ent_new.link   = bdst_pkg::LS_READY;
                                ent_new.status = ent.status | mask_reg;
                            end
                            else
                            begin
                                ent_new.link = bdst_pkg::LS_ABSENT;
                            end
                        end
                        default:
                        begin
                            res_next.result_code = bdst_pkg::RC_KIND;
                            res_next.forward     = 1'b0;
                        end
                    endcase
                    res_next.slot_status_out = ent_new.status;
                    mem_wr_en                = 1'b1;
                    mem_wr_data              = ent_new;
                end
                else
                begin
                    res_next.result_code     = send.rc;
                    res_next.slot_out        = ds_ext[3:0];
                    res_next.bus_addr_out    = send.bus_addr;
                    res_next.channel_out     = send.channel;
                    res_next.forward         = (send.rc == bdst_pkg::RC_OK);
                    res_next.slot_status_out = ent.status;
                    if (op_reg == bdst_pkg::OP_DISCONNECT)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = ent_chk;
                    end
                    else if ((op_reg == bdst_pkg::OP_APPROVE)
                             && (send.rc == bdst_pkg::RC_OK))
                    begin
                        ent_new.link = (appr_reg && (cur_idx_reg != '0))
                                       ? bdst_pkg::LS_ACK : bdst_pkg::LS_ABSENT;
                        mem_wr_en    = 1'b1;
                        mem_wr_data  = ent_new;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_idx_reg  <= '0;
            alloc_reg    <= 1'b0;
            scan_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
            free_vld_reg <= 1'b0;
            free_idx_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_idx_reg  <= cur_idx_next;
            alloc_reg    <= alloc_next;
            scan_reg     <= scan_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
            free_vld_reg <= free_vld_next;
            free_idx_reg <= free_idx_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Response beat
    assign rsp.valid           = out_vld_reg;
    assign rsp.result_code     = out_reg.result_code;
    assign rsp.slot_out        = out_reg.slot_out;
    assign rsp.bus_addr_out    = out_reg.bus_addr_out;
    assign rsp.channel_out     = out_reg.channel_out;
    assign rsp.forward         = out_reg.forward;
    assign rsp.slot_status_out = out_reg.slot_status_out;

    // A new result appears only from the result state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("response raised outside result state");

    // Forwarded beats always carry success
    a_fwd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.forward) |-> (rsp.result_code == bdst_pkg::RC_OK))
        else $error("forward set on a failed beat");

    // A full table reports no slot and no status
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.result_code == bdst_pkg::RC_FULL))
        |-> (!rsp.forward && (rsp.slot_out == 4'd0) && (rsp.slot_status_out == 8'd0)))
        else $error("table full beat carries data");

    // The scan never checks the controller slot
    a_scan_skips_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_vld_reg && (state_reg == S_SCAN)) |-> (chk_idx_reg != '0))
        else $error("scan reached slot zero");

    // Table writes happen only while executing
    a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |=> (state_reg == S_DONE))
        else $error("table write outside execute");

endmodule

### rtl/bdst_slot_mem.sv
module bdst_slot_mem #(
    parameter int NUM_SLOTS = bdst_pkg::NUM_SLOTS_DEF,
    parameter int IW        = $clog2(NUM_SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_addr,
    input  bdst_pkg::slot_entry_t wr_data,
    input  logic [IW-1:0]         rd_addr,
    output bdst_pkg::slot_entry_t rd_data
);

    bdst_pkg::slot_entry_t mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  written_reg;
    bdst_pkg::slot_entry_t rd_data_reg;
    logic                  rd_written_reg;

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Written flags: a never-written slot reads as absent with zero contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

### rtl/bdst_match.sv
module bdst_match (
    input  bdst_pkg::slot_entry_t entry,
    input  logic [7:0]            bus_addr,
    input  logic [5:0]            channel,
    output bdst_pkg::match_t      result
);

    // Compare one stored slot against the inbound key
    always_comb
    begin
        result.absent = (entry.link == bdst_pkg::LS_ABSENT);
        result.hit    = !result.absent && (entry.bus_addr == bus_addr)
                        && (entry.channel == channel);
    end

endmodule

### rtl/bdst_send_chk.sv
module bdst_send_chk (
    input  logic                  slot_zero,
    input  bdst_pkg::slot_entry_t entry,
    input  logic [5:0]            ctrl_channel,
    output bdst_pkg::send_chk_t   result
);

    logic [7:0] addr;
    logic [5:0] chan;
    logic [2:0] rc;

    // Map a slot to its bus address and channel, rejecting bad ones
    always_comb
    begin
        rc   = bdst_pkg::RC_OK;
        addr = entry.bus_addr;
        chan = entry.channel;
        if (slot_zero)
        begin
            addr = 8'd0;
            chan = ctrl_channel;
        end
        else if (entry.link == bdst_pkg::LS_ABSENT)
        begin
            rc = bdst_pkg::RC_ABSENT;
        end
        else if ((entry.bus_addr == 8'd0) || entry.bus_addr[0])
        begin
            rc = bdst_pkg::RC_ADDR;
        end
        if ((rc == bdst_pkg::RC_OK)
            && !(chan inside {[bdst_pkg::CHAN_MIN:bdst_pkg::CHAN_MAX]}))
        begin
            rc = bdst_pkg::RC_CHAN;
        end
        result.rc       = rc;
        result.bus_addr = (rc == bdst_pkg::RC_OK) ? addr : 8'd0;
        result.channel  = (rc == bdst_pkg::RC_OK) ? chan : 6'd0;
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_SLOTS = bdst_pkg::NUM_SLOTS_DEF;

    // Inbound kinds with no meaning to the table
    localparam logic [2:0] KIND_UNKNOWN     = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN_TOP = 3'd7;

    // Items per random phase
    localparam int PHASE_ITEMS = 300;
    localparam int NUM_PHASES  = 6;

    // Beat on the request channel
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] bus_addr;
        logic [5:0] channel;
        logic [2:0] msg_kind;
        logic [7:0] minor_code;
        logic [7:0] status_in;
        logic [4:0] dev_slot;
        logic       approve;
    } req_beat_t;

    // Directed row: request, plus a hand-written response where typed is set
    typedef struct packed {
        req_beat_t         beat;
        logic              typed;
        bdst_pkg::result_t rsp;
    } dir_row_t;

    localparam bdst_pkg::result_t NO_RSP = '0;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            wr_en;
    logic [bdst_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [bdst_pkg::CFG_DATA_W-1:0] wr_data;

    bdst_req_if req_if ();
    bdst_rsp_if rsp_if ();

    bus_device_slot_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the slot table and registers
    logic [1:0] tbl_link   [NUM_SLOTS];
    logic [7:0] tbl_addr   [NUM_SLOTS];
    logic [5:0] tbl_chan   [NUM_SLOTS];
    logic [7:0] tbl_status [NUM_SLOTS];
    logic [5:0] cfg_ctrl_chan;
    logic [7:0] cfg_link_mask;

    bdst_pkg::result_t exp_results[$];
    int                mismatches;
    int                snd_calm;
    logic              cur_typed;
    bdst_pkg::result_t cur_typed_rsp;
    dir_row_t          dir_tbl [25];

    function automatic req_beat_t mk_req(input logic [1:0] op, input logic [7:0] addr,
                                         input logic [5:0] chan, input logic [2:0] kind,
                                         input logic [7:0] minor, input logic [7:0] st,
                                         input logic [4:0] ds, input logic appr);
        return {op, addr, chan, kind, minor, st, ds, appr};
    endfunction

    function automatic bdst_pkg::result_t mk_rsp(input logic [2:0] rc,
                                                 input logic [3:0] slot,
                                                 input logic [7:0] addr,
                                                 input logic [5:0] chan,
                                                 input logic fwd, input logic [7:0] st);
        return {rc, slot, addr, chan, fwd, st};
    endfunction

    // Apply one request to the shadow table and return the response it yields
    function automatic bdst_pkg::result_t slot_table_step(input req_beat_t b);
        bdst_pkg::result_t r;
        int                s;
        logic              hit;
        logic [7:0]        a;
        logic [5:0]        c;
        r = '0;
        if (b.op == bdst_pkg::OP_INBOUND)
        begin
            s   = 0;
            hit = 1'b1;
            if (b.bus_addr != 8'd0)
            begin
                hit = 1'b0;
                // matching present slot first
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (!hit && tbl_link[i] != bdst_pkg::LS_ABSENT
                        && tbl_addr[i] == b.bus_addr && tbl_chan[i] == b.channel)
                    begin
                        s   = i;
                        hit = 1'b1;
                    end
                // else the first absent slot
                for (int i = 1; i < NUM_SLOTS; i++)
                    if (!hit && tbl_link[i] == bdst_pkg::LS_ABSENT)
                    begin
                        s             = i;
                        hit           = 1'b1;
                        tbl_link[i]   = bdst_pkg::LS_NEW;
                        tbl_addr[i]   = b.bus_addr;
                        tbl_chan[i]   = b.channel;
                        tbl_status[i] = 8'd0;
                    end
            end
            if (!hit)
                r.result_code = bdst_pkg::RC_FULL;
            else
            begin
                r.slot_out = 4'(s);
                r.forward  = 1'b1;
                case (b.msg_kind)
                    bdst_pkg::KIND_LONG_ID:
                        if (b.minor_code != bdst_pkg::MINOR_UNAVAIL)
                            tbl_status[s] = b.status_in;
                    bdst_pkg::KIND_PASSTHROUGH: ;
                    bdst_pkg::KIND_DISCONNECT:
                        tbl_link[s] = bdst_pkg::LS_ABSENT;
                    bdst_pkg::KIND_LINK_ACK:
                        if (b.minor_code == bdst_pkg::MINOR_ACCEPTED)
                        begin
                            tbl_link[s]   = bdst_pkg::LS_READY;
                            tbl_status[s] = tbl_status[s] | cfg_link_mask;
                        end
                        else
                            tbl_link[s] = bdst_pkg::LS_ABSENT;
                    default:
                    begin
                        r.result_code = bdst_pkg::RC_KIND;
                        r.forward     = 1'b0;
                    end
                endcase
                r.slot_status_out = tbl_status[s];
            end
        end
        else
        begin
            s          = int'(b.dev_slot);
            r.slot_out = b.dev_slot[3:0];
            // disconnect drops the slot before the send check
            if (b.op == bdst_pkg::OP_DISCONNECT && s < NUM_SLOTS)
                tbl_link[s] = bdst_pkg::LS_ABSENT;
            if (s >= NUM_SLOTS)
                r.result_code = bdst_pkg::RC_RANGE;
            else
            begin
                if (s == 0)
                begin
                    a = 8'd0;
                    c = cfg_ctrl_chan;
                end
                else
                begin
                    a = tbl_addr[s];
                    c = tbl_chan[s];
                end
                if (s != 0 && tbl_link[s] == bdst_pkg::LS_ABSENT)
                    r.result_code = bdst_pkg::RC_ABSENT;
                else if (s != 0 && (a == 8'd0 || a[0]))
                    r.result_code = bdst_pkg::RC_ADDR;
                else if (!(c inside {[bdst_pkg::CHAN_MIN:bdst_pkg::CHAN_MAX]}))
                    r.result_code = bdst_pkg::RC_CHAN;
                else
                begin
                    r.bus_addr_out = a;
                    r.channel_out  = c;
                    r.forward      = 1'b1;
                    if (b.op == bdst_pkg::OP_APPROVE)
                        tbl_link[s] = (b.approve && s != 0) ? bdst_pkg::LS_ACK
                                                            : bdst_pkg::LS_ABSENT;
                end
                r.slot_status_out = tbl_status[s];
            end
        end
        return r;
    endfunction

    // Wait count for one beat; now and then a stretch with no waits
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 30);
        return $urandom_range(0, 13);
    endfunction

    // Random request; churn favors freeing slots, otherwise the table fills up
    function automatic req_beat_t gen_random_beat(input logic churn);
        req_beat_t b;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < (churn ? 45 : 60))
            b.op = bdst_pkg::OP_INBOUND;
        else if (pick < (churn ? 65 : 80))
            b.op = bdst_pkg::OP_SEND;
        else if (pick < (churn ? 82 : 95))
            b.op = bdst_pkg::OP_APPROVE;
        else
            b.op = bdst_pkg::OP_DISCONNECT;

        // small pool of mostly even addresses so that inbound messages hit known slots
        pick = $urandom_range(0, 19);
        if (pick == 0)
            b.bus_addr = 8'd0;
        else if (pick < 3)
            b.bus_addr = 8'($urandom_range(0, 255));
        else
            b.bus_addr = 8'(2 * $urandom_range(1, 20)) | ((pick == 3) ? 8'd1 : 8'd0);

        pick = $urandom_range(0, 9);
        if (pick < 6)
            b.channel = 6'($urandom_range(1, 3));
        else if (pick == 6)
            b.channel = bdst_pkg::CHAN_MAX;
        else if (pick == 7)
            b.channel = 6'd0;
        else if (pick == 8)
            b.channel = bdst_pkg::CHAN_MAX + 6'd1;
        else
            b.channel = 6'($urandom_range(0, 63));

        pick = $urandom_range(0, 99);
        if (pick < (churn ? 30 : 40))
            b.msg_kind = bdst_pkg::KIND_LONG_ID;
        else if (pick < (churn ? 45 : 70))
            b.msg_kind = bdst_pkg::KIND_PASSTHROUGH;
        else if (pick < (churn ? 65 : 73))
            b.msg_kind = bdst_pkg::KIND_DISCONNECT;
        else if (pick < (churn ? 92 : 95))
            b.msg_kind = bdst_pkg::KIND_LINK_ACK;
        else
            b.msg_kind = 3'($urandom_range(KIND_UNKNOWN, KIND_UNKNOWN_TOP));

        if (b.msg_kind == bdst_pkg::KIND_LONG_ID && $urandom_range(0, 3) == 0)
            b.minor_code = bdst_pkg::MINOR_UNAVAIL;
        else if (b.msg_kind == bdst_pkg::KIND_LINK_ACK
                 && $urandom_range(0, 99) < (churn ? 50 : 85))
            b.minor_code = bdst_pkg::MINOR_ACCEPTED;
        else
            b.minor_code = 8'($urandom_range(0, 255));

        b.status_in = 8'($urandom_range(0, 255));
        b.dev_slot  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                                  : 5'($urandom_range(0, 15));
        b.approve   = ($urandom_range(0, 99) < (churn ? 50 : 80));
        return b;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Offer one request beat and hold it until accepted
    task automatic send_beat(input req_beat_t b, input logic typed,
                             input bdst_pkg::result_t rsp);
        int gap;
        gap = draw_wait(snd_calm);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.op         = b.op;
        req_if.bus_addr   = b.bus_addr;
        req_if.channel    = b.channel;
        req_if.msg_kind   = b.msg_kind;
        req_if.minor_code = b.minor_code;
        req_if.status_in  = b.status_in;
        req_if.dev_slot   = b.dev_slot;
        req_if.approve    = b.approve;
        cur_typed         = typed;
        cur_typed_rsp     = rsp;
        req_if.valid      = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and let every pending response come back
    task automatic drain_results();
        req_if.valid = 1'b0;
        while (exp_results.size() != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    // Response checking, prediction on accept and register shadowing
    always @(posedge clk)
    begin
        bdst_pkg::result_t want;
        bdst_pkg::result_t pred;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (exp_results.size() == 0)
                begin
                    $error("response beat with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = exp_results.pop_front();
                    check_field("result_code", want.result_code, rsp_if.result_code);
                    check_field("slot_out", want.slot_out, rsp_if.slot_out);
                    check_field("bus_addr_out", want.bus_addr_out, rsp_if.bus_addr_out);
                    check_field("channel_out", want.channel_out, rsp_if.channel_out);
                    check_field("forward", want.forward, rsp_if.forward);
                    check_field("slot_status_out", want.slot_status_out,
                                rsp_if.slot_status_out);
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                pred = slot_table_step({req_if.op, req_if.bus_addr, req_if.channel,
                                        req_if.msg_kind, req_if.minor_code,
                                        req_if.status_in, req_if.dev_slot,
                                        req_if.approve});
                exp_results.push_back(cur_typed ? cur_typed_rsp : pred);
            end
            if (wr_en)
                case (wr_index)
                    bdst_pkg::CFG_CTRL_CHANNEL: cfg_ctrl_chan = wr_data[5:0];
                    bdst_pkg::CFG_LINKED_MASK:  cfg_link_mask = wr_data;
                    default: ;
                endcase
        end
    end

    // Response side: random stalls, one long hold-off
    initial
    begin
        int n;
        int beats;
        int rcv_calm;
        logic held;
        rsp_if.ready = 1'b0;
        beats        = 0;
        rcv_calm     = 0;
        held         = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            n = draw_wait(rcv_calm);
            if (!held && beats >= 700)
            begin
                n    = 400;
                held = 1'b1;
            end
            if (n > 0)
            begin
                rsp_if.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
            @(posedge clk);
            while (!rsp_if.valid)
                @(posedge clk);
            beats++;
            @(negedge clk);
        end
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [7:0] ctrl_vals [NUM_PHASES];
        logic [7:0] mask_vals [NUM_PHASES];
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = bdst_pkg::CFG_CTRL_CHANNEL;
        wr_data           = '0;
        req_if.valid      = 1'b0;
        req_if.op         = bdst_pkg::OP_INBOUND;
        req_if.bus_addr   = '0;
        req_if.channel    = '0;
        req_if.msg_kind   = bdst_pkg::KIND_LONG_ID;
        req_if.minor_code = '0;
        req_if.status_in  = '0;
        req_if.dev_slot   = '0;
        req_if.approve    = 1'b0;
        cur_typed         = 1'b0;
        cur_typed_rsp     = NO_RSP;
        mismatches        = 0;
        snd_calm          = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_link[i]   = bdst_pkg::LS_ABSENT;
            tbl_addr[i]   = '0;
            tbl_chan[i]   = '0;
            tbl_status[i] = '0;
        end
        cfg_ctrl_chan = '0;
        cfg_link_mask = bdst_pkg::LINKED_MASK_RST;

        // Register settings per phase: extremes, window edges, random
        ctrl_vals = '{8'hFF, 8'h00, 8'h20, 8'h01, 8'h21, 8'($urandom_range(0, 255))};
        mask_vals = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255))};

        // Directed rows, run under the reset register values
        dir_tbl = '{
            // controller slot with channel 0 fails the channel window
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd0, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_CHAN, 4'd0, 8'd0, 6'd0, 1'b0, 8'd0)},
            // slot equal to the table size is out of range
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd16, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_RANGE, 4'd0, 8'd0, 6'd0, 1'b0, 8'd0)},
            {mk_req(bdst_pkg::OP_APPROVE, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd31, 1'b1),
             1'b1, mk_rsp(bdst_pkg::RC_RANGE, 4'd15, 8'd0, 6'd0, 1'b0, 8'd0)},
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd5, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_ABSENT, 4'd5, 8'd0, 6'd0, 1'b0, 8'd0)},
            // bus address 0 goes to the controller slot unchecked
            {mk_req(bdst_pkg::OP_INBOUND, 8'd0, 6'd63, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'hFF, 5'd0, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_OK, 4'd0, 8'd0, 6'd0, 1'b1, 8'hFF)},
            // unknown kind keeps the allocated slot
            {mk_req(bdst_pkg::OP_INBOUND, 8'hFF, 6'd63, KIND_UNKNOWN,
                    8'd0, 8'd0, 5'd0, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_KIND, 4'd1, 8'd0, 6'd0, 1'b0, 8'd0)},
            {mk_req(bdst_pkg::OP_INBOUND, 8'd2, 6'd1, KIND_UNKNOWN_TOP,
                    8'd0, 8'd0, 5'd0, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_INBOUND, 8'd2, 6'd1, bdst_pkg::KIND_LONG_ID,
                    8'h12, 8'hA5, 5'd0, 1'b0),
             1'b0, NO_RSP},
            // device unavailable leaves the status alone
            {mk_req(bdst_pkg::OP_INBOUND, 8'd2, 6'd1, bdst_pkg::KIND_LONG_ID,
                    bdst_pkg::MINOR_UNAVAIL, 8'h00, 5'd0, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_INBOUND, 8'd4, 6'd32, bdst_pkg::KIND_PASSTHROUGH,
                    8'd0, 8'd0, 5'd0, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd2, 1'b0),
             1'b0, NO_RSP},
            // odd bus address
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd1, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_ADDR, 4'd1, 8'd0, 6'd0, 1'b0, 8'd0)},
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd3, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_APPROVE, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd2, 1'b1),
             1'b0, NO_RSP},
            // accepted link ack ORs in the linked bit
            {mk_req(bdst_pkg::OP_INBOUND, 8'd2, 6'd1, bdst_pkg::KIND_LINK_ACK,
                    bdst_pkg::MINOR_ACCEPTED, 8'd0, 5'd0, 1'b0),
             1'b0, NO_RSP},
            // refused approve drops the slot
            {mk_req(bdst_pkg::OP_APPROVE, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd3, 1'b0),
             1'b0, NO_RSP},
            // rejected link ack drops the freshly allocated slot
            {mk_req(bdst_pkg::OP_INBOUND, 8'd6, 6'd0, bdst_pkg::KIND_LINK_ACK,
                    8'd5, 8'd0, 5'd0, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd3, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_INBOUND, 8'd8, 6'd33, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'h3C, 5'd0, 1'b0),
             1'b0, NO_RSP},
            // channel just above the window
            {mk_req(bdst_pkg::OP_SEND, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd3, 1'b0),
             1'b0, NO_RSP},
            // disconnect marks absent before the send check
            {mk_req(bdst_pkg::OP_DISCONNECT, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd2, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_DISCONNECT, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd0, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_APPROVE, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd0, 1'b1),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_INBOUND, 8'd8, 6'd33, bdst_pkg::KIND_DISCONNECT,
                    8'd0, 8'd0, 5'd0, 1'b0),
             1'b0, NO_RSP},
            {mk_req(bdst_pkg::OP_DISCONNECT, 8'd0, 6'd0, bdst_pkg::KIND_LONG_ID,
                    8'd0, 8'd0, 5'd20, 1'b0),
             1'b1, mk_rsp(bdst_pkg::RC_RANGE, 4'd4, 8'd0, 6'd0, 1'b0, 8'd0)}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tbl[i])
            send_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].rsp);

        // Random phases, registers rewritten while idle
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            wr_en    = 1'b1;
            wr_index = bdst_pkg::CFG_CTRL_CHANNEL;
            wr_data  = ctrl_vals[p];
            @(negedge clk);
            wr_index = bdst_pkg::CFG_LINKED_MASK;
            wr_data  = mask_vals[p];
            @(negedge clk);
            wr_en    = 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_beat(gen_random_beat(p % 2 == 1), 1'b0, NO_RSP);
        end

        drain_results();
        if (mismatches == 0 && exp_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/bdst_pkg.sv
rtl/bdst_if.sv
rtl/bdst_slot_mem.sv
rtl/bdst_match.sv
rtl/bdst_send_chk.sv
rtl/bus_device_slot_table.sv
test/tb.sv
